[src/vpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_pkg: shared definitions of the vibronic potential evaluator
// Sizes, request and result codes, controller commands, saturating helpers.
// ----------------------------------------------------------------------------
package vpe_pkg;

   localparam int MODES     = 32;
   localparam int STATES    = 4;
   localparam int ENTRIES   = STATES * STATES;

   localparam int DATA_W    = 32;
   localparam int KIND_W    = 2;
   localparam int MODE_W    = 5;
   localparam int ENTRY_W   = 4;
   localparam int CFG_W     = 6;
   localparam int ACC_W     = 48;
   localparam int EACC_W    = 64;
   localparam int PROD_W    = 64;
   localparam int FRAC      = 24;

   localparam int MODE_AW   = (MODES > 1) ? $clog2(MODES) : 1;
   localparam int ENT_AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ST_W      = (STATES > 1) ? $clog2(STATES) : 1;
   localparam int CPL_DEPTH = MODES * ENTRIES;
   localparam int CPL_AW    = (CPL_DEPTH > 1) ? $clog2(CPL_DEPTH) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 2);

   typedef enum logic [KIND_W-1:0] {
      KIND_SITE  = 2'd0,
      KIND_FREQ  = 2'd1,
      KIND_CPL   = 2'd2,
      KIND_COORD = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RES_GRAD   = 2'd0,
      RES_ENERGY = 2'd1,
      RES_POT    = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic              take_load;
      logic              take_coord;
      logic              mul_ww;
      logic              mul_gx;
      logic              mul_ex;
      logic              acc_e;
      logic              cpl_rd;
      logic [ENT_AW-1:0] cpl_idx;
      logic              cpl_diag;
      logic              out_grad;
      logic              out_energy;
      logic              out_pot;
      logic [ENT_AW-1:0] out_idx;
      logic              out_last;
      logic              clr_wr;
      logic [CPL_AW-1:0] clr_addr;
      logic              end_set;
   } vpe_cmd_type;

   typedef struct packed {
      logic coord_last;
   } vpe_status_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if ((&v[63:DATA_W-1]) || !(|v[63:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[63]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [EACC_W-1:0] add_sat64(input logic signed [EACC_W-1:0] a,
                                                         input logic signed [EACC_W-1:0] b);
      logic [EACC_W:0]          s;
      logic signed [EACC_W-1:0] r;
      s = {a[EACC_W-1], a} + {b[EACC_W-1], b};
      if (s[EACC_W] != s[EACC_W-1]) begin
         r = s[EACC_W] ? {1'b1, {(EACC_W-1){1'b0}}} : {1'b0, {(EACC_W-1){1'b1}}};
      end else begin
         r = s[EACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] add_sat48(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [PROD_W-1:0] b);
      logic [ACC_W:0]          s;
      logic signed [ACC_W-1:0] r;
      s = {a[ACC_W-1], a} + b[ACC_W:0];
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/vpe_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_if: request and result channels
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
interface vpe_req_if import vpe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [MODE_W-1:0]        mode_index;
   logic [ENTRY_W-1:0]       entry_index;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, kind, mode_index, entry_index, value, last, input ready);
   modport sink   (input valid, kind, mode_index, entry_index, value, last, output ready);
endinterface

interface vpe_rsp_if import vpe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        result_kind;
   logic [MODE_W-1:0]        out_mode;
   logic [ENTRY_W-1:0]       out_entry;
   logic signed [DATA_W-1:0] result_value;
   logic                     last_result;

   modport source (output valid, result_kind, out_mode, out_entry, result_value, last_result,
                   input ready);
   modport sink   (input valid, result_kind, out_mode, out_entry, result_value, last_result,
                   output ready);
endinterface

[src/vpe_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_datapath: tables, shared multiplier and accumulators
// Holds the site, frequency and coupling tables, one 32x32 multiplier,
// the energy and potential accumulators and the result register.
// ----------------------------------------------------------------------------
module vpe_datapath import vpe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  vpe_cmd_type              cmd,
   output vpe_status_type           status,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [MODE_W-1:0]        req_mode_index,
   input  logic [ENTRY_W-1:0]       req_entry_index,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data,
   output logic [KIND_W-1:0]        rsp_result_kind,
   output logic [MODE_W-1:0]        rsp_out_mode,
   output logic [ENTRY_W-1:0]       rsp_out_entry,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic                     rsp_last_result
);

   logic signed [DATA_W-1:0] site_ff [ENTRIES];
   logic signed [DATA_W-1:0] freq_ff [MODES];
   logic signed [ACC_W-1:0]  pot_ff  [ENTRIES];
   logic signed [DATA_W-1:0] cpl_mem [CPL_DEPTH];
   logic signed [EACC_W-1:0] energy_ff;
   logic                     fresh_ff;
   logic [CFG_W-1:0]         diag_ff;

   logic signed [DATA_W-1:0] x_ff;
   logic [MODE_W-1:0]        mode_ff;
   logic                     last_ff;
   logic                     mode_ok_ff;
   logic                     diag_only_ff;
   logic signed [DATA_W-1:0] grad_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     s1_vld_ff;
   logic [ENT_AW-1:0]        s1_idx_ff;
   logic                     s1_diag_ff;
   logic                     s2_vld_ff;
   logic [ENT_AW-1:0]        s2_idx_ff;
   logic                     s2_use_ff;

   logic [KIND_W-1:0]        out_kind_ff, out_kind_in;
   logic [MODE_W-1:0]        out_mode_ff, out_mode_in;
   logic [ENTRY_W-1:0]       out_entry_ff, out_entry_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic                     out_last_ff, out_last_in;

   logic                     mode_ok;
   logic                     entry_ok;
   logic [CPL_AW-1:0]        load_addr;
   logic [CPL_AW-1:0]        rd_addr;
   logic                     mem_we;
   logic [CPL_AW-1:0]        mem_addr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic signed [DATA_W-1:0] w_sel;
   logic signed [DATA_W-1:0] scaled;
   logic signed [DATA_W-1:0] op_a;
   logic signed [DATA_W-1:0] op_b;
   logic signed [PROD_W-1:0] prod_term;
   logic signed [63:0]       pot_sum;

   assign mode_ok   = int'(req_mode_index) < MODES;
   assign entry_ok  = int'(req_entry_index) < ENTRIES;
   assign load_addr = CPL_AW'(CPL_AW'(req_mode_index) * CPL_AW'(ENTRIES)
                              + CPL_AW'(req_entry_index));
   assign rd_addr   = CPL_AW'(CPL_AW'(mode_ff) * CPL_AW'(ENTRIES) + CPL_AW'(cmd.cpl_idx));

   assign mem_we    = cmd.clr_wr ||
                      (cmd.take_load && req_kind == KIND_CPL && mode_ok && entry_ok);
   assign mem_addr  = cmd.clr_wr ? cmd.clr_addr : load_addr;
   assign mem_wdata = cmd.clr_wr ? '0 : req_value;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cpl_mem[mem_addr] <= mem_wdata;
      end
      if (cmd.cpl_rd) begin
         rd_data_ff <= cpl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) site_ff[i] <= '0;
         for (int i = 0; i < MODES; i++) freq_ff[i] <= '0;
         diag_ff <= '0;
      end else begin
         if (cmd.take_load && req_kind == KIND_SITE && entry_ok) begin
            site_ff[ENT_AW'(req_entry_index)] <= req_value;
         end
         if (cmd.take_load && req_kind == KIND_FREQ && mode_ok) begin
            freq_ff[MODE_AW'(req_mode_index)] <= req_value;
         end
         if (csr_wr_en) begin
            diag_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_coord) begin
         x_ff         <= req_value;
         mode_ff      <= req_mode_index;
         last_ff      <= req_last;
         mode_ok_ff   <= mode_ok;
         diag_only_ff <= CFG_W'(req_mode_index) < diag_ff;
      end
   end

   assign w_sel  = mode_ok_ff ? freq_ff[MODE_AW'(mode_ff)] : '0;
   assign scaled = sat32(prod_ff >>> FRAC);

   always_comb begin
      if (cmd.mul_ww) begin
         op_a = w_sel;
         op_b = w_sel;
      end else if (cmd.mul_gx || cmd.mul_ex) begin
         op_a = scaled;
         op_b = x_ff;
      end else begin
         op_a = rd_data_ff;
         op_b = x_ff;
      end
      prod_in = op_a * op_b;
   end

   assign prod_term = prod_ff >>> FRAC;

   always_ff @(posedge clock) begin
      if (cmd.mul_ww || cmd.mul_gx || cmd.mul_ex || s1_vld_ff) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_ex) begin
         grad_ff <= scaled;
      end
      s1_idx_ff  <= cmd.cpl_idx;
      s1_diag_ff <= cmd.cpl_diag;
      s2_idx_ff  <= s1_idx_ff;
      s2_use_ff  <= mode_ok_ff && (!diag_only_ff || s1_diag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         fresh_ff  <= 1'b1;
      end else begin
         s1_vld_ff <= cmd.cpl_rd;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.take_coord && fresh_ff) begin
            fresh_ff <= 1'b0;
         end else if (cmd.end_set) begin
            fresh_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_coord && fresh_ff) begin
         energy_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) pot_ff[i] <= '0;
      end else begin
         if (cmd.acc_e) begin
            energy_ff <= add_sat64(energy_ff, prod_term);
         end
         if (s2_vld_ff && s2_use_ff) begin
            pot_ff[s2_idx_ff] <= add_sat48(pot_ff[s2_idx_ff], prod_term);
         end
      end
   end

   assign pot_sum = site_ff[cmd.out_idx] + pot_ff[cmd.out_idx];

   always_comb begin
      out_kind_in  = out_kind_ff;
      out_mode_in  = out_mode_ff;
      out_entry_in = out_entry_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_grad) begin
         out_kind_in  = RES_GRAD;
         out_mode_in  = mode_ff;
         out_entry_in = '0;
         out_value_in = grad_ff;
         out_last_in  = !last_ff;
      end else if (cmd.out_energy) begin
         out_kind_in  = RES_ENERGY;
         out_mode_in  = '0;
         out_entry_in = '0;
         out_value_in = sat32(64'(energy_ff >>> 1));
         out_last_in  = 1'b0;
      end else if (cmd.out_pot) begin
         out_kind_in  = RES_POT;
         out_mode_in  = '0;
         out_entry_in = ENTRY_W'(cmd.out_idx);
         out_value_in = sat32(pot_sum);
         out_last_in  = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_mode_ff  <= out_mode_in;
      out_entry_ff <= out_entry_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_result_kind   = out_kind_ff;
   assign rsp_out_mode      = out_mode_ff;
   assign rsp_out_entry     = out_entry_ff;
   assign rsp_result_value  = out_value_ff;
   assign rsp_last_result   = out_last_ff;
   assign status.coord_last = last_ff;

endmodule

[src/vpe_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_controller: sequencing of the evaluator
// Clears the coupling memory after reset, then steps each coordinate
// through the multiplier, the coupling pass and the result sequence.
// ----------------------------------------------------------------------------
module vpe_controller import vpe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  vpe_status_type    status,
   output vpe_cmd_type       cmd
);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_WW    = 9'b000000100,
      S_GX    = 9'b000001000,
      S_EX    = 9'b000010000,
      S_GOUT  = 9'b000100000,
      S_CPL   = 9'b001000000,
      S_EOUT  = 9'b010000000,
      S_POUT  = 9'b100000000
   } vpe_state_type;

   vpe_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ST_W-1:0]   row_ff, row_in;
   logic [ST_W-1:0]   col_ff, col_in;
   logic [CPL_AW-1:0] clr_addr_ff, clr_addr_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              slot_free;
   logic              load_out;

   assign slot_free = !rsp_vld_ff || rsp_ready;
   assign load_out  = cmd.out_grad || cmd.out_energy || cmd.out_pot;
   assign rsp_vld_in = (rsp_vld_ff && !rsp_ready) || load_out;

   always_comb begin
      cmd         = '0;
      req_ready   = 1'b0;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr   = 1'b1;
            cmd.clr_addr = clr_addr_ff;
            clr_addr_in  = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CPL_AW'(CPL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_COORD) begin
                  cmd.take_coord = 1'b1;
                  state_in       = S_WW;
               end else begin
                  cmd.take_load = 1'b1;
               end
            end
         end
         S_WW: begin
            cmd.mul_ww = 1'b1;
            state_in   = S_GX;
         end
         S_GX: begin
            cmd.mul_gx = 1'b1;
            state_in   = S_EX;
         end
         S_EX: begin
            cmd.mul_ex = 1'b1;
            state_in   = S_GOUT;
         end
         S_GOUT: begin
            if (slot_free) begin
               cmd.out_grad = 1'b1;
               cmd.acc_e    = 1'b1;
               cnt_in       = '0;
               row_in       = '0;
               col_in       = '0;
               state_in     = S_CPL;
            end
         end
         S_CPL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff < CNT_W'(ENTRIES)) begin
               cmd.cpl_rd   = 1'b1;
               cmd.cpl_idx  = ENT_AW'(cnt_ff);
               cmd.cpl_diag = row_ff == col_ff;
               if (col_ff == ST_W'(STATES - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            if (cnt_ff == CNT_W'(ENTRIES + 1)) begin
               state_in = status.coord_last ? S_EOUT : S_IDLE;
            end
         end
         S_EOUT: begin
            if (slot_free) begin
               cmd.out_energy = 1'b1;
               cnt_in         = '0;
               state_in       = S_POUT;
            end
         end
         S_POUT: begin
            if (slot_free) begin
               cmd.out_pot  = 1'b1;
               cmd.out_idx  = ENT_AW'(cnt_ff);
               cmd.out_last = cnt_ff == CNT_W'(ENTRIES - 1);
               cnt_in       = cnt_ff + 1'b1;
               if (cmd.out_last) begin
                  cmd.end_set = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         cnt_ff      <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         clr_addr_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         clr_addr_ff <= clr_addr_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;

`ifndef SYNTH
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_vld_ff || rsp_ready))
      else $error("result register overwritten while occupied");

   a_set_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_pot && cmd.out_last) |=> (state_ff == S_IDLE && rsp_vld_ff))
      else $error("final potential result not followed by idle");

   a_cpl_count_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CPL && $past(state_ff == S_CPL)) |-> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("coupling pass counter skipped");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_coord || cmd.take_load) |=> (state_ff == S_IDLE || state_ff == S_WW))
      else $error("request taken outside idle");
`endif

endmodule

[src/vibronic_potential_evaluator.sv]
`timescale 1ns / 1ps
// A coordinate runs the w*w, gradient and energy products, gives its gradient result, then makes
// the coupling pass; the last coordinate of a set adds the energy and potential results.
// Throughput: one load per cycle while idle; a new coordinate waits until the last is done.
// Its 16-entry coupling pass uses the single coupling memory read port and shared multiplier.
// Reset: synchronous; a clearing pass then zeroes the 512-entry coupling memory, one entry a
// cycle, before the first request is taken.
// ----------------------------------------------------------------------------
// vibronic_potential_evaluator: linear vibronic coupling potential
// Loads site energies, mode frequencies and couplings; per coordinate returns
// the gradient and accumulates harmonic energy and the potential matrix.
// ----------------------------------------------------------------------------
module vibronic_potential_evaluator import vpe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   vpe_req_if.sink          req_chan,
   vpe_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   vpe_cmd_type    cmd;
   vpe_status_type status;

   vpe_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   vpe_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_chan.kind),
      .req_mode_index   (req_chan.mode_index),
      .req_entry_index  (req_chan.entry_index),
      .req_value        (req_chan.value),
      .req_last         (req_chan.last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_result_kind  (rsp_chan.result_kind),
      .rsp_out_mode     (rsp_chan.out_mode),
      .rsp_out_entry    (rsp_chan.out_entry),
      .rsp_result_value (rsp_chan.result_value),
      .rsp_last_result  (rsp_chan.last_result)
   );

endmodule
